@@ src/asq_pkg.sv @@
// ----------------------------------------------------------------------------
// asq_pkg: shared types and constants for the affine sprite quad setup
//
// Holds the command codes, the default sizes and the payload types of the
// input and result channels.
// ----------------------------------------------------------------------------
package asq_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Command codes
  localparam logic [2:0] FN_SET   = 3'd0;
  localparam logic [2:0] FN_CAT   = 3'd1;
  localparam logic [2:0] FN_IDENT = 3'd2;
  localparam logic [2:0] FN_SAVE  = 3'd3;
  localparam logic [2:0] FN_REST  = 3'd4;
  localparam logic [2:0] FN_ALPHA = 3'd5;
  localparam logic [2:0] FN_DRAW  = 3'd6;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] arg0;
    logic signed [31:0] arg1;
    logic signed [31:0] arg2;
    logic signed [31:0] arg3;
    logic signed [31:0] arg4;
    logic signed [31:0] arg5;
    logic signed [31:0] arg6;
    logic signed [31:0] arg7;
    logic [3:0]         tex_width_log2;
    logic [3:0]         tex_height_log2;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic [7:0]         vertex_alpha;
    logic               tinted;
    logic [1:0]         corner;
    logic               last;
  } out_word_t;

  typedef logic signed [31:0] mword_t;
  typedef mword_t [5:0] matrix_t;

endpackage

@@ src/asq_if.sv @@
// ----------------------------------------------------------------------------
// asq_in_if / asq_out_if: valid/ready channels of the quad setup block
//
// A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface asq_in_if import asq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface asq_out_if import asq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/affine_sprite_quad_setup.sv @@
// ----------------------------------------------------------------------------
// affine_sprite_quad_setup: 2D command executor emitting sprite quad vertices
//
// Runs matrix, stack, alpha and draw commands; each draw gives four vertices.
// ----------------------------------------------------------------------------
// Commands enter through in_ch and vertices leave through out_ch, and a
// command is taken only while the block is idle. A draw holds the input
// until it has emitted its four vertices, computed on one pair of 32x32
// multipliers per screen axis that each vertex reuses, and it stalls while
// the output register stays full. A concatenate holds it for the accept,
// the two matrix column pairs, the translation pair, then the write-back.
// The save stack lives in one synchronous memory with one row of six words
// per entry. A restore holds the input for the accept, the memory read, then
// the row landing in the matrix. Every other command, and a restore on an
// empty stack, completes at its accept. Vertices pass through a one-word
// output register, so a new word is accepted while the last vertex waits.
// No new command is taken until a draw has emitted its last vertex.
module affine_sprite_quad_setup
  import asq_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  asq_in_if.sink   in_ch,
  asq_out_if.source out_ch
);

  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CAT  = 5'b00010,
    ST_DRAW = 5'b00100,
    ST_REST = 5'b01000,
    ST_WAIT = 5'b10000
  } state_t;

  state_t    state_r, state_nxt;
  matrix_t   mat_r;
  logic [SW-1:0] cnt_r;
  logic [7:0]    alpha_r;
  in_word_t  cmd_r;
  logic [1:0] step_r;
  matrix_t   new_r;
  matrix_t   stack_mem [STACK_DEPTH];
  matrix_t   rd_r;
  logic      ov_r;
  out_word_t ov_data_r;

  // Accept when idle; a draw waits in ST_DRAW for the output slot
  logic out_free;
  assign out_free = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  // Saturating 33-bit edge
  function automatic logic signed [31:0] sat_edge(input logic signed [31:0] b,
                                                  input logic signed [31:0] l);
    logic signed [32:0] s;
    s = 33'(b) + 33'(l);
    if (s > 33'sh07fffffff) return 32'sh7fffffff;
    if (s < -33'sh080000000) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Concatenate step: two products (plus translation on the translation step), floored and saturated
  logic signed [31:0] p0a, p0b, p1a, p1b;
  logic signed [31:0] cat_out0, cat_out1;
  logic signed [65:0] cs0, cs1;
  always_comb begin
    p0a = mat_r[0]; p0b = mat_r[1]; p1a = mat_r[2]; p1b = mat_r[3];
    cs0 = '0; cs1 = '0;
    unique case (step_r)
      2'd0: begin
        cs0 = 66'(p0a * 64'(cmd_r.arg0)) + 66'(p0b * 64'(cmd_r.arg2));
        cs1 = 66'(p0a * 64'(cmd_r.arg1)) + 66'(p0b * 64'(cmd_r.arg3));
      end
      2'd1: begin
        cs0 = 66'(p1a * 64'(cmd_r.arg0)) + 66'(p1b * 64'(cmd_r.arg2));
        cs1 = 66'(p1a * 64'(cmd_r.arg1)) + 66'(p1b * 64'(cmd_r.arg3));
      end
      default: begin
        cs0 = 66'(p0a * 64'(cmd_r.arg4)) + 66'(p0b * 64'(cmd_r.arg5)) +
              (66'(mat_r[4]) <<< FRAC_BITS);
        cs1 = 66'(p1a * 64'(cmd_r.arg4)) + 66'(p1b * 64'(cmd_r.arg5)) +
              (66'(mat_r[5]) <<< FRAC_BITS);
      end
    endcase
  end

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] q;
    q = v >>> FRAC_BITS;
    if (q > 66'sh07fffffff) return 32'sh7fffffff;
    if (q < -66'sh080000000) return 32'sh80000000;
    return q[31:0];
  endfunction
  assign cat_out0 = sat32(cs0);
  assign cat_out1 = sat32(cs1);

  // Draw vertex for corner step_r
  logic hx, hy;
  logic signed [31:0] vx, vy, u0, u1, v0, v1;
  logic signed [65:0] sx, sy, fx, fy;
  out_word_t vert;
  always_comb begin
    hx = (step_r == 2'd1) || (step_r == 2'd2);
    hy = step_r[1];
    vx = hx ? sat_edge(cmd_r.arg0, cmd_r.arg2) : cmd_r.arg0;
    vy = hy ? sat_edge(cmd_r.arg1, cmd_r.arg3) : cmd_r.arg1;
    u0 = cmd_r.arg4 >>> cmd_r.tex_width_log2;
    u1 = sat_edge(cmd_r.arg4, cmd_r.arg6) >>> cmd_r.tex_width_log2;
    v0 = cmd_r.arg5 >>> cmd_r.tex_height_log2;
    v1 = sat_edge(cmd_r.arg5, cmd_r.arg7) >>> cmd_r.tex_height_log2;
    sx = 66'(mat_r[0] * 64'(vx)) + 66'(mat_r[2] * 64'(vy)) +
         (66'(mat_r[4]) <<< FRAC_BITS);
    sy = 66'(mat_r[1] * 64'(vx)) + 66'(mat_r[3] * 64'(vy)) +
         (66'(mat_r[5]) <<< FRAC_BITS);
    fx = sx >>> (2 * FRAC_BITS);
    fy = sy >>> (2 * FRAC_BITS);
    vert.pos_x = (fx > 66'sd32767) ? 16'sh7fff :
                 (fx < -66'sd32768) ? 16'sh8000 : fx[15:0];
    vert.pos_y = (fy > 66'sd32767) ? 16'sh7fff :
                 (fy < -66'sd32768) ? 16'sh8000 : fy[15:0];
    vert.tex_u = hx ? u1 : u0;
    vert.tex_v = hy ? v1 : v0;
    vert.vertex_alpha = alpha_r;
    vert.tinted = (alpha_r != 8'hff);
    vert.corner = step_r;
    vert.last = (step_r == 2'd3);
  end

  logic emit;
  assign emit = (state_r == ST_DRAW) && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_ch.data.func == FN_CAT) state_nxt = ST_CAT;
          else if (in_ch.data.func == FN_DRAW) state_nxt = ST_DRAW;
          else if (in_ch.data.func == FN_REST && cnt_r != '0) state_nxt = ST_REST;
        end
      end
      ST_CAT:  if (step_r == 2'd3) state_nxt = ST_IDLE;
      ST_DRAW: if (emit && step_r == 2'd3) state_nxt = ST_IDLE;
      ST_REST: state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Stack memory: write on save, registered read on restore
  always_ff @(posedge clk) begin
    if (acc && in_ch.data.func == FN_SAVE && cnt_r < SW'(STACK_DEPTH)) begin
      stack_mem[cnt_r[AW-1:0]] <= mat_r;
    end
    if (state_r == ST_REST) begin
      rd_r <= stack_mem[cnt_r[AW-1:0]];
    end
  end

  // Control and matrix state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mat_r   <= '{32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, ONE};
      cnt_r   <= '0;
      alpha_r <= 8'hff;
      step_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Load the output slot on emit, else drain it when taken
      if (emit) begin
        ov_r      <= 1'b1;
        ov_data_r <= vert;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (acc) begin
        cmd_r  <= in_ch.data;
        step_r <= '0;
        unique case (in_ch.data.func)
          FN_SET: mat_r <= {in_ch.data.arg5, in_ch.data.arg4, in_ch.data.arg3,
                            in_ch.data.arg2, in_ch.data.arg1, in_ch.data.arg0};
          FN_IDENT: mat_r <= '{32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, ONE};
          FN_SAVE: if (cnt_r < SW'(STACK_DEPTH)) cnt_r <= cnt_r + 1'b1;
          FN_REST: if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
          FN_ALPHA: alpha_r <= in_ch.data.arg0[7:0];
          default: ;
        endcase
      end
      // Concatenate: columns then translation, then commit
      if (state_r == ST_CAT) begin
        step_r <= step_r + 1'b1;
        unique case (step_r)
          2'd0: begin new_r[0] <= cat_out0; new_r[1] <= cat_out1; end
          2'd1: begin new_r[2] <= cat_out0; new_r[3] <= cat_out1; end
          2'd2: begin new_r[4] <= cat_out0; new_r[5] <= cat_out1; end
          default: mat_r <= new_r;
        endcase
      end
      if (emit) step_r <= step_r + 1'b1;
      if (state_r == ST_WAIT) mat_r <= rd_r;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = ov_data_r;

endmodule
